[rtl/mscdt_pkg.sv]
// Package for the multi-slot countdown timer table.
// Holds the command and status codes, the timer memory entry type and the result cap.
// Depends on nothing.
package mscdt_pkg;

  localparam int MAX_RESULTS = 16;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_SLOT = 2'd2;

  typedef struct packed {
    logic [15:0] remaining;
    logic [15:0] tag;
  } entry_t;

endpackage

[rtl/multi_slot_countdown_timer.sv]
// Top level of the multi-slot countdown timer table.
// Uses mscdt_pkg for codes and the entry type; counts and tags live in one memory.
//
// A table of SLOTS one-shot timers. Counts and tags sit in a single-port-write,
// single-port-read memory with a registered read; occupancy is kept in
// flip-flops and cleared by reset. A tick walks the memory one slot per cycle,
// reading, decrementing and writing back, but holds on a firing slot while the
// result register is full and stalled. An add scans occupancy one slot per cycle.
// Cancel and clear go straight to their response. A full, stalled result register
// holds any response back. A new beat is taken only when the previous command is
// finished.
module multi_slot_countdown_timer
  import mscdt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_seconds,
  input  logic [15:0] in_tag,
  input  logic [7:0]  in_slot_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_fired,
  output logic [3:0]  out_slot,
  output logic [15:0] out_fired_tag,
  output logic        out_last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_TICK,
    S_FLUSH,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [SLOTS-1:0]   occ_r, occ_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [15:0]        secs_r, secs_nxt;
  logic [15:0]        tag_r, tag_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [3:0]         pend_slot_r, pend_slot_nxt;
  logic [15:0]        pend_tag_r, pend_tag_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic               out_fired_r, out_fired_nxt;
  logic [3:0]         out_slot_r, out_slot_nxt;
  logic [15:0]        out_tag_r, out_tag_nxt;
  logic               out_last_r, out_last_nxt;

  entry_t             mem [SLOTS];
  entry_t             rdata_r;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;

  logic               out_free;
  logic               cur_occ;
  logic               dec;
  logic               fire;
  logic               blocked;

  assign out_free = !out_valid_r || !out_stall;
  assign cur_occ  = occ_r[idx_r];
  assign dec      = cur_occ && (rdata_r.remaining != 16'd0);
  assign fire     = dec && (rdata_r.remaining == 16'd1) && (cnt_r < CNT_W'(MAX_RESULTS));
  assign blocked  = fire && pend_valid_r && !out_free;

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    secs_nxt       = secs_r;
    tag_nxt        = tag_r;
    res_status_nxt = res_status_r;
    pend_valid_nxt = pend_valid_r;
    pend_slot_nxt  = pend_slot_r;
    pend_tag_nxt   = pend_tag_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_fired_nxt  = out_fired_r;
    out_slot_nxt   = out_slot_r;
    out_tag_nxt    = out_tag_r;
    out_last_nxt   = out_last_r;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = rdata_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          secs_nxt = in_seconds;
          tag_nxt  = in_tag;
          idx_nxt  = '0;
          case (kind_t'(in_kind))
            KIND_TICK: begin
              mem_re         = 1'b1;
              cnt_nxt        = '0;
              pend_valid_nxt = 1'b0;
              state_nxt      = S_TICK;
            end
            KIND_ADD: begin
              state_nxt = S_ADD;
            end
            KIND_CANCEL: begin
              if ({1'b0, in_slot_number} < 9'(SLOTS)) begin
                occ_nxt[in_slot_number[IDX_W-1:0]] = 1'b0;
                res_status_nxt = ST_OK;
              end else begin
                res_status_nxt = ST_BAD_SLOT;
              end
              state_nxt = S_EMIT;
            end
            default: begin
              occ_nxt        = '0;
              res_status_nxt = ST_OK;
              state_nxt      = S_EMIT;
            end
          endcase
        end
      end

      S_ADD: begin
        if (!cur_occ) begin
          if (out_free) begin
            mem_we           = 1'b1;
            mem_wdata        = '{remaining: secs_r, tag: tag_r};
            occ_nxt[idx_r]   = 1'b1;
            out_valid_nxt    = 1'b1;
            out_status_nxt   = ST_OK;
            out_fired_nxt    = 1'b0;
            out_slot_nxt     = 4'(idx_r);
            out_tag_nxt      = 16'd0;
            out_last_nxt     = 1'b1;
            state_nxt        = S_IDLE;
          end
        end else if (idx_r == LAST_IDX) begin
          res_status_nxt = ST_NO_SPACE;
          state_nxt      = S_EMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_TICK: begin
        if (!blocked) begin
          if (dec) begin
            mem_we    = 1'b1;
            mem_wdata = '{remaining: rdata_r.remaining - 16'd1, tag: rdata_r.tag};
          end
          if (fire) begin
            if (pend_valid_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_fired_nxt  = 1'b1;
              out_slot_nxt   = pend_slot_r;
              out_tag_nxt    = pend_tag_r;
              out_last_nxt   = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_slot_nxt  = 4'(idx_r);
            pend_tag_nxt   = rdata_r.tag;
            cnt_nxt        = cnt_r + 1'b1;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = idx_r + 1'b1;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_fired_nxt  = 1'b1;
          out_slot_nxt   = pend_slot_r;
          out_tag_nxt    = pend_tag_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_fired_nxt  = 1'b0;
          out_slot_nxt   = 4'd0;
          out_tag_nxt    = 16'd0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      occ_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
      idx_r        <= idx_nxt;
    end
    secs_r       <= secs_nxt;
    tag_r        <= tag_nxt;
    res_status_r <= res_status_nxt;
    pend_slot_r  <= pend_slot_nxt;
    pend_tag_r   <= pend_tag_nxt;
    out_status_r <= out_status_nxt;
    out_fired_r  <= out_fired_nxt;
    out_slot_r   <= out_slot_nxt;
    out_tag_r    <= out_tag_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_fired     = out_fired_r;
  assign out_slot      = out_slot_r;
  assign out_fired_tag = out_tag_r;
  assign out_last      = out_last_r;

endmodule

[rtl/mscdt_checker.sv]
// Port-level checker for the multi-slot countdown timer table, bound to the top level.
// Uses mscdt_pkg for the status codes.
module mscdt_checker
  import mscdt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_kind,
  input logic [15:0] in_seconds,
  input logic [15:0] in_tag,
  input logic [7:0]  in_slot_number,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic        out_fired,
  input logic [3:0]  out_slot,
  input logic [15:0] out_fired_tag,
  input logic        out_last
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable({in_kind, in_seconds, in_tag,
                                                  in_slot_number}))
    else $error("Stalled input beat was withdrawn or changed.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Result beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable({out_status, out_fired, out_slot, out_fired_tag,
                                        out_last}))
    else $error("Stalled result beat changed.");

  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fired |-> out_status == ST_OK)
    else $error("A fired timer beat carries an error status.");

  a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fired |-> out_last && out_fired_tag == 16'd0)
    else $error("A command response is not a single final beat with a zero tag.");

endmodule

bind multi_slot_countdown_timer mscdt_checker u_mscdt_checker (.*);
